// ===== design/ple_pkg.sv =====
`default_nettype none
package ple_pkg;

    localparam int KIND_W     = 3;
    localparam int POS_W      = 7;
    localparam int VALUE_W    = 32;
    localparam int CNT_OUT_W  = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [KIND_W-1:0] KIND_READ      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OVERWRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_UP,
        ST_DOWN,
        ST_PUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   read_value;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_empty;
        logic                 is_full;
    } result_t;

endpackage
`default_nettype wire

// ===== design/ple_ram.sv =====
`default_nettype none
module ple_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [ple_pkg::VALUE_W-1:0] rd_data,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [ple_pkg::VALUE_W-1:0] wr_data
);
    import ple_pkg::*;

    logic [VALUE_W-1:0] mem_reg [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/ple_ctrl.sv =====
`default_nettype none
module ple_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire ple_pkg::request_t           req,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output ple_pkg::result_t                 res,
    output logic                             mem_rd_en,
    output logic      [AW-1:0]               mem_rd_addr,
    input  wire logic [ple_pkg::VALUE_W-1:0] mem_rd_data,
    output logic                             mem_wr_en,
    output logic      [AW-1:0]               mem_wr_addr,
    output logic      [ple_pkg::VALUE_W-1:0] mem_wr_data
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      left_reg, left_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               ok_reg, ok_next;
    logic [VALUE_W-1:0] rdval_reg, rdval_next;

    logic [LW-1:0] pos_l;
    logic [LW-1:0] cnt_l;
    logic          in_list;
    logic          ins_ok;
    logic          ins_tail;
    logic          accept;

    assign pos_l    = LW'(req.position);
    assign cnt_l    = LW'(count_reg);
    assign in_list  = (pos_l != '0) && (pos_l <= cnt_l);
    assign ins_ok   = (cnt_l < LW'(DEPTH)) && (pos_l != '0) && (pos_l <= cnt_l + LW'(1));
    assign ins_tail = (pos_l == cnt_l + LW'(1));
    assign accept   = req_valid && req_ready;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb
    begin
        res.ok         = ok_reg;
        res.read_value = rdval_reg;
        res.count      = CNT_OUT_W'(count_reg);
        res.is_empty   = (count_reg == '0);
        res.is_full    = (count_reg == CW'(DEPTH));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DONE;
                    case (req.kind)
                        KIND_READ:
                        begin
                            if (in_list)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (ins_ok && !ins_tail)
                            begin
                                state_next = ST_UP;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (in_list)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if ((kind_reg == KIND_REMOVE) && (left_reg != '0))
                begin
                    state_next = ST_DOWN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_UP:
            begin
                if (left_reg == '0)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_DOWN:
            begin
                if (left_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PUT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        count_next  = count_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        val_next    = val_reg;
        kind_next   = kind_reg;
        ok_next     = ok_reg;
        rdval_next  = rdval_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = mem_rd_data;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    val_next   = req.value;
                    ok_next    = 1'b0;
                    rdval_next = '0;
                    case (req.kind)
                        KIND_READ:
                        begin
                            if (in_list)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(pos_l - LW'(1));
                                left_next   = '0;
                                ok_next     = 1'b1;
                            end
                        end
                        KIND_OVERWRITE:
                        begin
                            if (in_list)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = AW'(pos_l - LW'(1));
                                mem_wr_data = req.value;
                                ok_next     = 1'b1;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                count_next = CW'(count_reg + 1'b1);
                                ok_next    = 1'b1;
                                if (ins_tail)
                                begin
                                    mem_wr_en   = 1'b1;
                                    mem_wr_addr = AW'(pos_l - LW'(1));
                                    mem_wr_data = req.value;
                                end
                                else
                                begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = AW'(cnt_l - LW'(1));
                                    addr_next   = AW'(cnt_l - LW'(1));
                                    left_next   = AW'(cnt_l - pos_l);
                                end
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (in_list)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(pos_l - LW'(1));
                                addr_next   = AW'(pos_l - LW'(1));
                                left_next   = AW'(cnt_l - pos_l);
                                count_next  = CW'(count_reg - 1'b1);
                                ok_next     = 1'b1;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                rdval_next = mem_rd_data;
                if ((kind_reg == KIND_REMOVE) && (left_reg != '0))
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(addr_reg + 1'b1);
                    addr_next   = AW'(addr_reg + 1'b1);
                    left_next   = AW'(left_reg - 1'b1);
                end
            end
            ST_UP:
            begin
                // move the entry read last cycle one place up
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(addr_reg + 1'b1);
                mem_wr_data = mem_rd_data;
                if (left_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(addr_reg - 1'b1);
                    addr_next   = AW'(addr_reg - 1'b1);
                    left_next   = AW'(left_reg - 1'b1);
                end
            end
            ST_DOWN:
            begin
                // move the entry read last cycle one place down
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(addr_reg - 1'b1);
                mem_wr_data = mem_rd_data;
                if (left_reg != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(addr_reg + 1'b1);
                    addr_next   = AW'(addr_reg + 1'b1);
                    left_next   = AW'(left_reg - 1'b1);
                end
            end
            ST_PUT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = addr_reg;
                mem_wr_data = val_reg;
            end
            ST_DONE:
            begin
                mem_rd_en = 1'b0;
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        val_reg   <= val_next;
        kind_reg  <= kind_next;
        ok_reg    <= ok_next;
        rdval_reg <= rdval_next;
    end

endmodule
`default_nettype wire

// ===== design/positional_list_engine.sv =====
`default_nettype none
// channel     dir  handshake                       payload
// s_axis      in   s_axis_tvalid / s_axis_tready   s_axis_tdata: kind, position, value
// m_axis      out  m_axis_tvalid / m_axis_tready   m_axis_tdata: ok, read_value, count,
//                                                  is_empty, is_full
//
// one request at a time; the list lives in one ram with one read and one write port
// read fetches the entry from the ram; overwrite, clear, a failed request and insert at the tail need no fetch
// insert below the tail moves entries up then writes the value, remove moves entries down (one entry moved a cycle)
// reset empties the list; entries are not cleared
// a result waits in the output register, a new request is taken while it stalls
module positional_list_engine #(
    parameter int DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // kind [2:0], position [9:3], value [41:10], zero [47:42]
    input  wire logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // ok [0], read_value [32:1], count [39:33], is_empty [40], is_full [41], zero [47:42]
    output logic      [ple_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    localparam int AW = $clog2(DEPTH);

    request_t           req;
    result_t            res;
    logic               res_valid;
    logic               res_ready;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic [VALUE_W-1:0] mem_rd_data;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [VALUE_W-1:0] mem_wr_data;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    always_comb
    begin
        req.kind     = s_axis_tdata[KIND_W-1:0];
        req.position = s_axis_tdata[KIND_W+POS_W-1:KIND_W];
        req.value    = s_axis_tdata[KIND_W+POS_W+VALUE_W-1:KIND_W+POS_W];
    end

    ple_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    ple_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready)
        begin
            m_valid_next = res_valid;
            if (res_valid)
            begin
                m_data_next = M_TDATA_W'({res.is_full, res.is_empty, res.count,
                                          res.read_value, res.ok});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== design/ple_checker.sv =====
`default_nettype none
module ple_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [ple_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import ple_pkg::*;

    logic [KIND_W-1:0] s_kind;
    assign s_kind = s_axis_tdata[KIND_W-1:0];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // failed request reports no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == '0)
        else $error("failed request carries data");

    // empty flag follows count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[40] == (m_axis_tdata[39:33] == '0))
        else $error("empty flag disagrees with count");

    // a clear request never fails
    a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_kind == KIND_CLEAR && !m_axis_tvalid
        |-> ##2 m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[40])
        else $error("clear did not give an empty list");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
